>>> sv/ssds_pkg.sv
// ----------------------------------------------------------------------------
// ssds_pkg
// shared widths, codes and types of the sign split dual stack
// ----------------------------------------------------------------------------
package ssds_pkg;

  localparam int unsigned CLASS_CAP   = 32;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned MAX_RESULTS = 32;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIM_W    = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(CLASS_CAP + 1);
  localparam int unsigned NRES_W = $clog2(MAX_RESULTS + 1);

  localparam int unsigned LC_W = (LIM_W > CNT_W) ? LIM_W : CNT_W;
  localparam int unsigned RC_W = (CNT_W > NRES_W) ? CNT_W : NRES_W;

  localparam int unsigned IN_TDATA_W  = ((KIND_W + WORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((STATUS_W + WORD_W + 7) / 8) * 8;

  localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(32);

  localparam logic [CFG_IDX_W-1:0] REG_NONNEG_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_LIMIT    = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH     = 3'd0,
    KIND_POP_NN   = 3'd1,
    KIND_POP_NG   = 3'd2,
    KIND_LIST_NN  = 3'd3,
    KIND_LIST_NG  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADKIND = 2'd3
  } status_e;

  typedef struct packed {
    logic [CNT_W-1:0] nonneg;
    logic [CNT_W-1:0] neg;
  } lim_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              busy;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  nn_cnt;
    logic [CNT_W-1:0]  ng_cnt;
  } stat_t;

endpackage

>>> sv/ssds_store.sv
// ----------------------------------------------------------------------------
// ssds_store
// word store: one write and one read port, registered read data
// ----------------------------------------------------------------------------
module ssds_store (
  input  logic                             clk_i,
  input  ssds_pkg::mem_req_t               req_i,
  output logic [ssds_pkg::WORD_W-1:0]      rdata_o
);
  import ssds_pkg::*;

  logic [WORD_W-1:0] mem_q [STORE_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ssds_ctrl.sv
// ----------------------------------------------------------------------------
// ssds_ctrl
// command sequencer: push, scan for pop and list, shift down after a pop
// ----------------------------------------------------------------------------
module ssds_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_vld_i,
  output logic                              in_rdy_o,
  input  logic [ssds_pkg::KIND_W-1:0]       kind_i,
  input  logic [ssds_pkg::WORD_W-1:0]       value_i,
  output logic                              out_vld_o,
  input  logic                              out_rdy_i,
  output logic [ssds_pkg::STATUS_W-1:0]     status_o,
  output logic [ssds_pkg::WORD_W-1:0]       data_o,
  output logic                              last_o,
  input  ssds_pkg::lim_t                    lim_i,
  output ssds_pkg::mem_req_t                req_o,
  input  logic [ssds_pkg::WORD_W-1:0]       rdata_i,
  output ssds_pkg::stat_t                   stat_o
);
  import ssds_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT
  } state_e;

  state_e            state_q, state_d;
  logic              neg_q, neg_d;
  logic              pop_q, pop_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic              rdv_q, rdv_d;
  logic [ADDR_W-1:0] chk_q, chk_d;
  logic [FILL_W-1:0] src_q, src_d;
  logic [NRES_W-1:0] emit_q, emit_d;
  logic [NRES_W-1:0] tot_q, tot_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  nn_cnt_q, nn_cnt_d;
  logic [CNT_W-1:0]  ng_cnt_q, ng_cnt_d;
  logic              out_vld_q, out_vld_d;
  status_e           out_status_q, out_status_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic              out_free;
  logic              acc;
  logic              push_neg;
  logic [CNT_W-1:0]  push_cnt;
  logic [CNT_W-1:0]  push_lim;
  logic              cmd_neg;
  logic [CNT_W-1:0]  cmd_cnt;
  logic              match;
  logic [NRES_W-1:0] list_tot;
  logic              list_last;
  mem_req_t          req;

  assign out_free = !out_vld_q || out_rdy_i;
  assign in_rdy_o = (state_q == IDLE) && out_free;
  assign acc      = in_vld_i && in_rdy_o;

  assign push_neg = value_i[WORD_W-1];
  assign push_cnt = push_neg ? ng_cnt_q : nn_cnt_q;
  assign push_lim = push_neg ? lim_i.neg : lim_i.nonneg;

  assign cmd_neg  = (kind_e'(kind_i) == KIND_POP_NG) || (kind_e'(kind_i) == KIND_LIST_NG);
  assign cmd_cnt  = cmd_neg ? ng_cnt_q : nn_cnt_q;
  assign list_tot = (RC_W'(cmd_cnt) < RC_W'(MAX_RESULTS)) ? NRES_W'(cmd_cnt)
                                                           : NRES_W'(MAX_RESULTS);

  assign match     = rdv_q && (rdata_i[WORD_W-1] == neg_q);
  assign list_last = ((emit_q + NRES_W'(1)) == tot_q);

  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    pop_d        = pop_q;
    rem_d        = rem_q;
    rdv_d        = rdv_q;
    chk_d        = chk_q;
    src_d        = src_q;
    emit_d       = emit_q;
    tot_d        = tot_q;
    fill_d       = fill_q;
    nn_cnt_d     = nn_cnt_q;
    ng_cnt_d     = ng_cnt_q;
    out_vld_d    = out_vld_q && !out_rdy_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    req          = '0;

    case (state_q)
      IDLE: begin
        if (acc) begin
          out_data_d = '0;
          out_last_d = 1'b1;
          case (kind_e'(kind_i))
            KIND_PUSH: begin
              out_vld_d = 1'b1;
              if (push_cnt >= push_lim || fill_q >= FILL_W'(STORE_DEPTH)) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d = ST_OK;
                req.we       = 1'b1;
                req.waddr    = fill_q[ADDR_W-1:0];
                req.wdata    = value_i;
                fill_d       = fill_q + FILL_W'(1);
                if (push_neg) begin
                  ng_cnt_d = ng_cnt_q + CNT_W'(1);
                end else begin
                  nn_cnt_d = nn_cnt_q + CNT_W'(1);
                end
              end
            end
            KIND_POP_NN, KIND_POP_NG, KIND_LIST_NN, KIND_LIST_NG: begin
              if (cmd_cnt == '0) begin
                out_vld_d    = 1'b1;
                out_status_d = ST_EMPTY;
              end else begin
                state_d = SCAN;
                neg_d   = cmd_neg;
                pop_d   = (kind_e'(kind_i) == KIND_POP_NN) ||
                          (kind_e'(kind_i) == KIND_POP_NG);
                rem_d   = fill_q;
                rdv_d   = 1'b0;
                emit_d  = '0;
                tot_d   = list_tot;
              end
            end
            default: begin
              out_vld_d    = 1'b1;
              out_status_d = ST_BADKIND;
            end
          endcase
        end
      end

      SCAN: begin
        // a matching word waits in the read register while the output is full
        if (!match || out_free) begin
          if (match) begin
            out_vld_d    = 1'b1;
            out_status_d = ST_OK;
            out_data_d   = rdata_i;
            out_last_d   = pop_q || list_last;
            emit_d       = emit_q + NRES_W'(1);
          end
          if (match && pop_q) begin
            state_d = SHIFT;
            src_d   = FILL_W'(chk_q) + FILL_W'(1);
            rdv_d   = 1'b0;
          end else if (match && list_last) begin
            state_d = IDLE;
            rdv_d   = 1'b0;
          end else if (rem_q != '0) begin
            req.re    = 1'b1;
            req.raddr = ADDR_W'(rem_q - FILL_W'(1));
            chk_d     = ADDR_W'(rem_q - FILL_W'(1));
            rem_d     = rem_q - FILL_W'(1);
            rdv_d     = 1'b1;
          end else begin
            rdv_d = 1'b0;
          end
        end
      end

      SHIFT: begin
        // read one entry up, write it one entry down in the next cycle
        if (rdv_q) begin
          req.we    = 1'b1;
          req.waddr = chk_q - ADDR_W'(1);
          req.wdata = rdata_i;
        end
        if (src_q < fill_q) begin
          req.re    = 1'b1;
          req.raddr = src_q[ADDR_W-1:0];
          chk_d     = src_q[ADDR_W-1:0];
          src_d     = src_q + FILL_W'(1);
          rdv_d     = 1'b1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            state_d = IDLE;
            fill_d  = fill_q - FILL_W'(1);
            if (neg_q) begin
              ng_cnt_d = ng_cnt_q - CNT_W'(1);
            end else begin
              nn_cnt_d = nn_cnt_q - CNT_W'(1);
            end
          end
        end
      end

      default: begin
        state_d = IDLE;
        rdv_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      rdv_q     <= 1'b0;
      fill_q    <= '0;
      nn_cnt_q  <= '0;
      ng_cnt_q  <= '0;
      out_vld_q <= 1'b0;
      neg_q     <= 1'b0;
      pop_q     <= 1'b0;
      rem_q     <= '0;
      src_q     <= '0;
      emit_q    <= '0;
      tot_q     <= '0;
    end else begin
      state_q   <= state_d;
      rdv_q     <= rdv_d;
      fill_q    <= fill_d;
      nn_cnt_q  <= nn_cnt_d;
      ng_cnt_q  <= ng_cnt_d;
      out_vld_q <= out_vld_d;
      neg_q     <= neg_d;
      pop_q     <= pop_d;
      rem_q     <= rem_d;
      src_q     <= src_d;
      emit_q    <= emit_d;
      tot_q     <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q        <= chk_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  assign req_o     = req;
  assign out_vld_o = out_vld_q;
  assign status_o  = out_status_q;
  assign data_o    = out_data_q;
  assign last_o    = out_last_q;

  assign stat_o.busy   = (state_q != IDLE);
  assign stat_o.fill   = fill_q;
  assign stat_o.nn_cnt = nn_cnt_q;
  assign stat_o.ng_cnt = ng_cnt_q;

endmodule

>>> sv/sign_split_dual_stack.sv
// ----------------------------------------------------------------------------
// sign_split_dual_stack
// two lifo classes (non-negative, negative words) in one ordered store
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | tdata: kind[2:0], value[34:3]
//  m_axis    | out       | tdata: status[1:0], data[33:2]; tlast: last word of a command
//  cfg       | in        | write 0 nonneg_limit, 1 neg_limit
//
//  push, invalid kind, empty pop or list: result registered straight into the output register
//  pop: scan from the newest word down to the hit, then shift the words above the hit down,
//  no shift when the hit is the newest word; one store access per direction per cycle
//  list: scan from the newest word down, one word per cycle unless the output register is full
//  reset clears counts and fill level; store contents are not cleared
//  a full output register stalls the scan; new commands wait for the sequencer
// ----------------------------------------------------------------------------
module sign_split_dual_stack (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ssds_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // kind, value
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ssds_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // status, data
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [ssds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ssds_pkg::LIM_W-1:0]           cfg_wdata_i
);
  import ssds_pkg::*;

  logic [LIM_W-1:0]    nn_lim_q;
  logic [LIM_W-1:0]    ng_lim_q;
  lim_t                lim;
  mem_req_t            req;
  logic [WORD_W-1:0]   rdata;
  stat_t               stat;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nn_lim_q <= LIM_RST;
      ng_lim_q <= LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NONNEG_LIMIT: nn_lim_q <= cfg_wdata_i;
        REG_NEG_LIMIT:    ng_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective limit is the register clipped to the class capacity
  assign lim.nonneg = (LC_W'(nn_lim_q) < LC_W'(CLASS_CAP)) ? CNT_W'(nn_lim_q)
                                                          : CNT_W'(CLASS_CAP);
  assign lim.neg    = (LC_W'(ng_lim_q) < LC_W'(CLASS_CAP)) ? CNT_W'(ng_lim_q)
                                                          : CNT_W'(CLASS_CAP);

  ssds_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  ssds_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .kind_i    (s_axis_tdata[KIND_W-1:0]),
    .value_i   (s_axis_tdata[KIND_W+WORD_W-1:KIND_W]),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .status_o  (status),
    .data_o    (data),
    .last_o    (m_axis_tlast),
    .lim_i     (lim),
    .req_o     (req),
    .rdata_i   (rdata),
    .stat_o    (stat)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W - WORD_W){1'b0}}, data, status};

  a_fill_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    FILL_W'(stat.nn_cnt) + FILL_W'(stat.ng_cnt) == stat.fill)
    else $error("fill level differs from class counts");

  a_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RC_W'(stat.nn_cnt) <= RC_W'(CLASS_CAP)) && (RC_W'(stat.ng_cnt) <= RC_W'(CLASS_CAP)))
    else $error("class count above capacity");

  a_rdy_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stat.busy)
    else $error("command taken while sequencer busy");

  a_fail_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status != ST_OK)) |-> (data == '0) && m_axis_tlast)
    else $error("failure word carries data or is not last");

endmodule

>>> tb/sv/sign_split_dual_stack_tb.sv
// ----------------------------------------------------------------------------
// sign_split_dual_stack_tb
// self-checking bench: random and directed stack commands on the input stream,
// every output word checked against a behavioral mirror of both classes
// ----------------------------------------------------------------------------
module sign_split_dual_stack_tb;
  import ssds_pkg::*;

  localparam logic [KIND_W-1:0] KIND_FIRST_BAD = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LAST_BAD  = 3'd7;
  localparam int unsigned       DRAIN_CYCLES   = 200;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
  } stack_cmd_t;

  typedef struct {
    status_e           status;
    logic [WORD_W-1:0] data;
    logic              last;
  } stack_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // kind, value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // status, data
  logic                   m_axis_tlast;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [LIM_W-1:0]       cfg_wdata_i;

  stack_cmd_t    cmd_q[$];
  stack_cmd_t    next_cmd;
  stack_result_t due_words[$];
  stack_result_t want;
  logic          word_taken;
  int            src_idle_pct;
  int            sink_idle_pct;
  int            n_errors;

  // mirror of the block state
  logic [WORD_W-1:0] mirror_store[$];
  int                nn_cnt;
  int                ng_cnt;
  logic [LIM_W-1:0]  nn_lim;
  logic [LIM_W-1:0]  ng_lim;

  sign_split_dual_stack u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void post_word(status_e st, logic [WORD_W-1:0] data, logic last);
    stack_result_t r;
    r.status = st;
    r.data   = data;
    r.last   = last;
    due_words.push_back(r);
  endfunction

  // works out the words one command produces and updates the mirror
  function automatic void compute_stack_response(logic [KIND_W-1:0] kind,
                                                 logic [WORD_W-1:0] value);
    logic              want_neg;
    int                cnt;
    int                lim;
    int                idx;
    int                n;
    logic [WORD_W-1:0] w;
    case (kind)
      KIND_PUSH: begin
        want_neg = value[WORD_W-1];
        cnt = want_neg ? ng_cnt : nn_cnt;
        lim = want_neg ? int'(ng_lim) : int'(nn_lim);
        if (lim > int'(CLASS_CAP)) lim = CLASS_CAP;
        if (cnt >= lim || mirror_store.size() >= int'(STORE_DEPTH)) begin
          post_word(ST_FULL, '0, 1'b1);
        end else begin
          mirror_store.push_back(value);
          if (want_neg) ng_cnt++;
          else nn_cnt++;
          post_word(ST_OK, '0, 1'b1);
        end
      end
      KIND_POP_NN, KIND_POP_NG: begin
        want_neg = (kind == KIND_POP_NG);
        cnt = want_neg ? ng_cnt : nn_cnt;
        if (cnt == 0 || mirror_store.size() == 0) begin
          post_word(ST_EMPTY, '0, 1'b1);
        end else begin
          for (idx = mirror_store.size() - 1; idx > 0; idx--) begin
            if (mirror_store[idx][WORD_W-1] == want_neg) break;
          end
          w = mirror_store[idx];
          mirror_store.delete(idx);
          if (want_neg) ng_cnt--;
          else nn_cnt--;
          post_word(ST_OK, w, 1'b1);
        end
      end
      KIND_LIST_NN, KIND_LIST_NG: begin
        want_neg = (kind == KIND_LIST_NG);
        n = 0;
        for (idx = mirror_store.size() - 1; idx >= 0 && n < int'(MAX_RESULTS); idx--) begin
          if (mirror_store[idx][WORD_W-1] == want_neg) begin
            post_word(ST_OK, mirror_store[idx], 1'b0);
            n++;
          end
        end
        if (n == 0) post_word(ST_EMPTY, '0, 1'b1);
        else due_words[due_words.size()-1].last = 1'b1;
      end
      default: begin
        post_word(ST_BADKIND, '0, 1'b1);
      end
    endcase
  endfunction

  // monitor: sampled at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got status %0d data %h last %0b",
                 $time, m_axis_tdata[STATUS_W-1:0], m_axis_tdata[STATUS_W +: WORD_W],
                 m_axis_tlast);
        n_errors++;
      end else begin
        want = due_words.pop_front();
        if (m_axis_tdata[STATUS_W-1:0] !== want.status ||
            m_axis_tdata[STATUS_W +: WORD_W] !== want.data ||
            m_axis_tlast !== want.last) begin
          $display("%0t: word mismatch: expected status %0d data %h last %0b, got status %0d data %h last %0b",
                   $time, want.status, want.data, want.last, m_axis_tdata[STATUS_W-1:0],
                   m_axis_tdata[STATUS_W +: WORD_W], m_axis_tlast);
          n_errors++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      compute_stack_response(s_axis_tdata[KIND_W-1:0], s_axis_tdata[KIND_W +: WORD_W]);
      word_taken = 1'b1;
    end
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        REG_NONNEG_LIMIT: nn_lim = cfg_wdata_i;
        REG_NEG_LIMIT:    ng_lim = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // driver: inputs change at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    if (!s_axis_tvalid || word_taken) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_cmd = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({next_cmd.value, next_cmd.kind});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  task automatic queue_cmd(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
    stack_cmd_t c;
    c.kind  = kind;
    c.value = value;
    cmd_q.push_back(c);
  endtask

  // holds the sender until every word has come back, then lets a pop finish
  task automatic wait_drained();
    while (cmd_q.size() != 0 || s_axis_tvalid || due_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limits(input int nn, input int ng);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_NONNEG_LIMIT;
    cfg_wdata_i <= LIM_W'(nn);
    @(negedge clk_i);
    cfg_idx_i   <= REG_NEG_LIMIT;
    cfg_wdata_i <= LIM_W'(ng);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int nn, input int ng, input int push_pct, input int neg_pct,
                           input int n_cmds, input int src_pct, input int sink_pct);
    stack_cmd_t c;
    int         pick;
    int         i;
    wait_drained();
    write_limits(nn, ng);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (i = 0; i < n_cmds; i++) begin
      c.value = $urandom;
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: c.value = 32'h0000_0000;
          1: c.value = 32'h7fff_ffff;
          2: c.value = 32'h8000_0000;
          default: c.value = 32'hffff_ffff;
        endcase
      end else begin
        c.value[WORD_W-1] = ($urandom_range(99) < neg_pct);
      end
      if ($urandom_range(99) < push_pct) begin
        c.kind = KIND_PUSH;
      end else begin
        pick = $urandom_range(19);
        if (pick < 9) c.kind = pick[0] ? KIND_POP_NG : KIND_POP_NN;
        else if (pick < 17) c.kind = pick[0] ? KIND_LIST_NG : KIND_LIST_NN;
        else c.kind = KIND_FIRST_BAD + KIND_W'($urandom_range(2));
      end
      cmd_q.push_back(c);
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_NONNEG_LIMIT;
    cfg_wdata_i   = '0;
    word_taken    = 1'b0;
    nn_cnt        = 0;
    ng_cnt        = 0;
    nn_lim        = LIM_RST;
    ng_lim        = LIM_RST;
    n_errors      = 0;
    src_idle_pct  = 26;
    sink_idle_pct = 73;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // invalid kinds, empty classes, sign extremes, gap closing on pop
    queue_cmd(KIND_FIRST_BAD, 32'hffff_ffff);
    queue_cmd(KIND_FIRST_BAD + 3'd1, 32'h0000_0000);
    queue_cmd(KIND_LAST_BAD, 32'h8000_0000);
    queue_cmd(KIND_POP_NN, 32'h0000_0000);
    queue_cmd(KIND_POP_NG, 32'hffff_ffff);
    queue_cmd(KIND_LIST_NN, 32'h0000_0000);
    queue_cmd(KIND_LIST_NG, 32'h0000_0000);
    queue_cmd(KIND_PUSH, 32'h0000_0000);
    queue_cmd(KIND_PUSH, 32'h7fff_ffff);
    queue_cmd(KIND_PUSH, 32'h8000_0000);
    queue_cmd(KIND_PUSH, 32'hffff_ffff);
    queue_cmd(KIND_PUSH, 32'h0000_0001);
    queue_cmd(KIND_LIST_NN, 32'h0000_0000);
    queue_cmd(KIND_LIST_NG, 32'h0000_0000);
    queue_cmd(KIND_POP_NG, 32'h0000_0000);
    queue_cmd(KIND_POP_NN, 32'h0000_0000);
    queue_cmd(KIND_LIST_NN, 32'h0000_0000);
    queue_cmd(KIND_LIST_NG, 32'h0000_0000);
    queue_cmd(KIND_POP_NN, 32'h0000_0000);
    queue_cmd(KIND_POP_NN, 32'h0000_0000);
    queue_cmd(KIND_POP_NN, 32'h0000_0000);
    queue_cmd(KIND_POP_NG, 32'h0000_0000);
    queue_cmd(KIND_POP_NG, 32'h0000_0000);

    // fill up, then drop the limits below the counts held
    run_phase(32, 32, 75, 50, 70, 26, 73);
    run_phase(3, 0, 40, 50, 60, 26, 73);
    run_phase(63, 1, 60, 20, 60, 73, 26);
    run_phase(0, 63, 60, 80, 60, 73, 26);
    // nonneg class to its cap, then negative too so the store runs full
    run_phase(32, 32, 80, 10, 80, 0, 0);
    run_phase(32, 63, 80, 90, 90, 0, 0);
    wait_drained();

    if (n_errors == 0) begin
      $display("sign_split_dual_stack_tb: clean");
    end else begin
      $display("sign_split_dual_stack_tb: errors");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("sign_split_dual_stack_tb: errors");
    $finish;
  end

endmodule

>>> files.f
sv/ssds_pkg.sv
sv/ssds_store.sv
sv/ssds_ctrl.sv
sv/sign_split_dual_stack.sv
tb/sv/sign_split_dual_stack_tb.sv
